/* sv/ptcc_pkg.sv */
// Package for the palette table with color cycling.
// Holds the field widths, the opcode, status and sequencer state types, and the register map.
// No dependencies.
package ptcc_pkg;

  localparam int DEFAULT_ENTRIES = 256;

  localparam int INDEX_W    = 8;
  localparam int BYTE_W     = 8;
  localparam int AMOUNT_W   = 16;
  localparam int COLOR_W    = 24;
  localparam int PARTIAL_W  = 16;
  localparam int CFG_W      = 3;
  localparam int LEN_W      = INDEX_W + 1;
  localparam int APB_ADDR_W = 2;
  localparam int APB_DATA_W = 32;

  localparam logic [APB_ADDR_W-1:0] REG_BYTES_PER_ENTRY = '0;
  localparam logic [CFG_W-1:0]      BPE_RESET           = CFG_W'(3);
  localparam logic [CFG_W-1:0]      BPE_FOUR            = CFG_W'(4);

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_READ,
    OP_ROTATE,
    OP_NOP
  } opcode_t;

  typedef enum logic [1:0] {
    STAT_OK,
    STAT_LOAD_LEN,
    STAT_RANGE
  } status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_DIVIDE,
    ST_COPY_OUT,
    ST_DRAIN,
    ST_COPY_BACK,
    ST_FINISH
  } state_t;

endpackage

/* sv/palette_table_with_color_cycling.sv */
// Palette store with load, read and range rotate (color cycling) transactions.
// Depends on ptcc_pkg.
//
// An operation is taken when start is high and busy is low; its result is on red, green, blue
// and status for one cycle with done high, and the receiver cannot stall it. A load byte or an
// unused opcode gives its result in the cycle after it is taken and never raises busy. A read
// raises busy while it waits in the read state and gives its result from the registered read
// port of the color memory. A valid rotate keeps busy high while it runs the bit-serial
// remainder unit, copies the range (len = range_final - range_first + 1) into a staging memory
// at rotated positions, passes a drain state, copies the range back, and passes a finish state;
// an invalid range answers at once.
// After reset a clearing pass zeroes every entry of the color memory with busy high.
module palette_table_with_color_cycling #(
  parameter int PALETTE_ENTRIES = ptcc_pkg::DEFAULT_ENTRIES
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ptcc_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [ptcc_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [ptcc_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          opcode,
  input  logic [ptcc_pkg::BYTE_W-1:0]         load_byte,
  input  logic                                load_last,
  input  logic [ptcc_pkg::INDEX_W-1:0]        read_index,
  input  logic [ptcc_pkg::INDEX_W-1:0]        range_first,
  input  logic [ptcc_pkg::INDEX_W-1:0]        range_final,
  input  logic [ptcc_pkg::AMOUNT_W-1:0]       rotate_amount,
  output logic                                done,
  output logic [ptcc_pkg::BYTE_W-1:0]         red,
  output logic [ptcc_pkg::BYTE_W-1:0]         green,
  output logic [ptcc_pkg::BYTE_W-1:0]         blue,
  output logic [1:0]                          status
);

  localparam int AW         = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam int ExpLen3    = PALETTE_ENTRIES * 3;
  localparam int ExpLen4    = PALETTE_ENTRIES * 4;
  localparam int CountLimit = PALETTE_ENTRIES * 4 + 1;
  localparam int CW         = $clog2(CountLimit + 1);
  localparam int LW         = ptcc_pkg::LEN_W;
  localparam int DCW        = $clog2(ptcc_pkg::AMOUNT_W);

  ptcc_pkg::state_t  state, state_next;
  ptcc_pkg::opcode_t op;

  logic [ptcc_pkg::CFG_W-1:0]   bytes_per_entry;
  logic [ptcc_pkg::COLOR_W-1:0] color_store [PALETTE_ENTRIES];
  logic [ptcc_pkg::COLOR_W-1:0] rot_buf [PALETTE_ENTRIES];
  logic [ptcc_pkg::COLOR_W-1:0] st_rd_data;
  logic [ptcc_pkg::COLOR_W-1:0] buf_rd_data;

  logic                          accept;
  logic                          st_rd_en;
  logic [AW-1:0]                 st_rd_addr;
  logic                          st_we;
  logic [AW-1:0]                 st_wa;
  logic [ptcc_pkg::COLOR_W-1:0]  st_wd;
  logic [AW-1:0]                 clr_addr;

  logic [CW-1:0]                 ld_count, ld_count_new, ld_idx, idx3;
  logic [1:0]                    pos3, ld_pos;
  logic [ptcc_pkg::PARTIAL_W-1:0] partial;
  logic                          ld_inc, ld_write, bpe4;
  ptcc_pkg::status_t             ld_status;

  logic                          rd_ok;
  logic                          rot_ok;
  logic [ptcc_pkg::INDEX_W-1:0]  rng_first;
  logic [LW-1:0]                 len, cnt_i, cnt_j, rem, trial, rem_step;
  logic [ptcc_pkg::AMOUNT_W-1:0] dividend;
  logic [DCW-1:0]                div_cnt;
  logic                          at_last;
  logic [AW-1:0]                 range_addr;
  logic                          bw_en, sw_en;
  logic [AW-1:0]                 bw_addr, sw_addr;

  logic                          res_valid;
  logic [ptcc_pkg::COLOR_W-1:0]  res_color;
  ptcc_pkg::status_t             res_status;

  assign pready = 1'b1;
  assign prdata = (paddr == ptcc_pkg::REG_BYTES_PER_ENTRY)
                  ? ptcc_pkg::APB_DATA_W'(bytes_per_entry) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_per_entry <= ptcc_pkg::BPE_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr == ptcc_pkg::REG_BYTES_PER_ENTRY) begin
      bytes_per_entry <= pwdata[ptcc_pkg::CFG_W-1:0];
    end
  end

  assign op     = ptcc_pkg::opcode_t'(opcode);
  assign busy   = (state != ptcc_pkg::ST_IDLE);
  assign accept = start && !busy;

  // load position and entry index for the current format
  assign bpe4         = (bytes_per_entry == ptcc_pkg::BPE_FOUR);
  assign ld_pos       = bpe4 ? ld_count[1:0] : pos3;
  assign ld_idx       = bpe4 ? (ld_count >> 2) : idx3;
  assign ld_inc       = (ld_count < CW'(CountLimit));
  assign ld_count_new = ld_inc ? ld_count + CW'(1) : ld_count;
  assign ld_status    = (ld_count_new != (bpe4 ? CW'(ExpLen4) : CW'(ExpLen3)))
                        ? ptcc_pkg::STAT_LOAD_LEN : ptcc_pkg::STAT_OK;
  assign ld_write     = accept && op == ptcc_pkg::OP_LOAD && ld_pos == 2'd2 &&
                        int'(ld_idx) < PALETTE_ENTRIES;

  assign rot_ok = (range_final >= range_first) && int'(range_final) < PALETTE_ENTRIES;

  assign trial      = {rem[LW-2:0], dividend[ptcc_pkg::AMOUNT_W-1]};
  assign rem_step   = (trial >= len) ? trial - len : trial;
  assign at_last    = (cnt_i == len - LW'(1));
  assign range_addr = AW'({1'b0, rng_first} + cnt_i);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ptcc_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    res_valid  = 1'b0;
    res_color  = '0;
    res_status = ptcc_pkg::STAT_OK;
    st_rd_en   = 1'b0;
    st_rd_addr = range_addr;
    unique case (state)
      ptcc_pkg::ST_CLEAR: begin
        if (clr_addr == AW'(PALETTE_ENTRIES - 1)) state_next = ptcc_pkg::ST_IDLE;
      end
      ptcc_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (op)
            ptcc_pkg::OP_LOAD: begin
              res_valid = 1'b1;
              if (load_last) res_status = ld_status;
            end
            ptcc_pkg::OP_READ: begin
              st_rd_en   = 1'b1;
              st_rd_addr = AW'(read_index);
              state_next = ptcc_pkg::ST_READ;
            end
            ptcc_pkg::OP_ROTATE: begin
              if (rot_ok) begin
                state_next = ptcc_pkg::ST_DIVIDE;
              end else begin
                res_valid  = 1'b1;
                res_status = ptcc_pkg::STAT_RANGE;
              end
            end
            ptcc_pkg::OP_NOP: res_valid = 1'b1;
          endcase
        end
      end
      ptcc_pkg::ST_READ: begin
        res_valid  = 1'b1;
        res_color  = rd_ok ? st_rd_data : '0;
        state_next = ptcc_pkg::ST_IDLE;
      end
      ptcc_pkg::ST_DIVIDE: begin
        if (div_cnt == '0) state_next = ptcc_pkg::ST_COPY_OUT;
      end
      ptcc_pkg::ST_COPY_OUT: begin
        st_rd_en = 1'b1;
        if (at_last) state_next = ptcc_pkg::ST_DRAIN;
      end
      ptcc_pkg::ST_DRAIN: state_next = ptcc_pkg::ST_COPY_BACK;
      ptcc_pkg::ST_COPY_BACK: begin
        if (at_last) state_next = ptcc_pkg::ST_FINISH;
      end
      ptcc_pkg::ST_FINISH: begin
        res_valid  = 1'b1;
        state_next = ptcc_pkg::ST_IDLE;
      end
      default: state_next = ptcc_pkg::ST_IDLE;
    endcase
  end

  // color memory write port: clearing pass, copy-back, load
  always_comb begin
    st_we = 1'b0;
    st_wa = ld_idx[AW-1:0];
    st_wd = {partial, load_byte};
    if (state == ptcc_pkg::ST_CLEAR) begin
      st_we = 1'b1;
      st_wa = clr_addr;
      st_wd = '0;
    end else if (sw_en) begin
      st_we = 1'b1;
      st_wa = sw_addr;
      st_wd = buf_rd_data;
    end else if (ld_write) begin
      st_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (st_we) color_store[st_wa] <= st_wd;
    if (st_rd_en) st_rd_data <= color_store[st_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (bw_en) rot_buf[bw_addr] <= st_rd_data;
    if (state == ptcc_pkg::ST_COPY_BACK) buf_rd_data <= rot_buf[AW'(cnt_i)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == ptcc_pkg::ST_CLEAR) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ld_count <= '0;
      pos3     <= '0;
      idx3     <= '0;
      partial  <= '0;
    end else if (accept && op == ptcc_pkg::OP_LOAD) begin
      if (load_last) begin
        ld_count <= '0;
        pos3     <= '0;
        idx3     <= '0;
        partial  <= '0;
      end else begin
        ld_count <= ld_count_new;
        if (ld_inc) begin
          pos3 <= (pos3 == 2'd2) ? 2'd0 : pos3 + 2'd1;
          if (pos3 == 2'd2) idx3 <= idx3 + CW'(1);
        end
        if (ld_pos == 2'd0) partial <= {load_byte, partial[7:0] & 8'h00};
        else if (ld_pos == 2'd1) partial <= {partial[15:8], load_byte};
      end
    end
  end

  // rotate datapath: remainder unit and copy counters
  always_ff @(posedge clk) begin
    if (rst) begin
      bw_en <= 1'b0;
      sw_en <= 1'b0;
    end else begin
      bw_en <= (state == ptcc_pkg::ST_COPY_OUT);
      sw_en <= (state == ptcc_pkg::ST_COPY_BACK);
    end
  end

  always_ff @(posedge clk) begin
    bw_addr <= AW'(cnt_j);
    sw_addr <= range_addr;
    if (state == ptcc_pkg::ST_IDLE && accept) begin
      rd_ok     <= int'(read_index) < PALETTE_ENTRIES;
      rng_first <= range_first;
      len       <= {1'b0, range_final} - {1'b0, range_first} + LW'(1);
      dividend  <= rotate_amount;
      rem       <= '0;
      div_cnt   <= DCW'(ptcc_pkg::AMOUNT_W - 1);
      cnt_i     <= '0;
    end
    unique case (state)
      ptcc_pkg::ST_DIVIDE: begin
        rem      <= rem_step;
        cnt_j    <= rem_step;
        dividend <= dividend << 1;
        div_cnt  <= div_cnt - DCW'(1);
      end
      ptcc_pkg::ST_COPY_OUT: begin
        cnt_i <= cnt_i + LW'(1);
        cnt_j <= (cnt_j == len - LW'(1)) ? '0 : cnt_j + LW'(1);
      end
      ptcc_pkg::ST_DRAIN:     cnt_i <= '0;
      ptcc_pkg::ST_COPY_BACK: cnt_i <= cnt_i + LW'(1);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      red    <= res_color[23:16];
      green  <= res_color[15:8];
      blue   <= res_color[7:0];
      status <= res_status;
    end
  end

endmodule

/* sv/ptcc_checker.sv */
// Port-level checker for the palette table with color cycling, and its bind.
// Depends on ptcc_pkg and palette_table_with_color_cycling.
module ptcc_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic [1:0]  opcode,
  input logic        done,
  input logic [7:0]  red,
  input logic [7:0]  green,
  input logic [7:0]  blue,
  input logic [1:0]  status
);

  a_clear_after_reset: assert property (@(posedge clk) $fell(rst) |-> busy)
    else $error("clearing pass not running after reset");

  a_load_one_cycle: assert property (@(posedge clk) disable iff (rst)
    start && !busy && opcode == ptcc_pkg::OP_LOAD |=> done && !busy)
    else $error("load transaction result missing");

  a_read_two_cycles: assert property (@(posedge clk) disable iff (rst)
    start && !busy && opcode == ptcc_pkg::OP_READ |=> busy && !done ##1 done)
    else $error("read transaction timing wrong");

  a_error_no_color: assert property (@(posedge clk) disable iff (rst)
    done && status != ptcc_pkg::STAT_OK |-> red == 8'd0 && green == 8'd0 && blue == 8'd0)
    else $error("color on an error result");

  a_status_legal: assert property (@(posedge clk) disable iff (rst)
    done |-> status == ptcc_pkg::STAT_OK || status == ptcc_pkg::STAT_LOAD_LEN ||
             status == ptcc_pkg::STAT_RANGE)
    else $error("unknown status code");

endmodule

bind palette_table_with_color_cycling ptcc_checker u_ptcc_checker (.*);

/* bench/tb.sv */
// Testbench for palette_table_with_color_cycling: drives load, read and rotate transactions and
// programs the entry format over APB, predicting every result with an internal palette model.
// Depends on ptcc_pkg and the palette_table_with_color_cycling RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ENTRIES       = ptcc_pkg::DEFAULT_ENTRIES;
  localparam int COUNT_LIMIT   = ENTRIES * 4 + 1;
  localparam int IDLE_PCT      = 27;
  localparam int QUIET_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 16;
  localparam int FIRST_PART    = 40;

  typedef struct {
    ptcc_pkg::opcode_t             op;
    logic [ptcc_pkg::BYTE_W-1:0]   byte_val;
    logic                          is_last;
    logic [ptcc_pkg::INDEX_W-1:0]  rd_index;
    logic [ptcc_pkg::INDEX_W-1:0]  first;
    logic [ptcc_pkg::INDEX_W-1:0]  top_idx;
    logic [ptcc_pkg::AMOUNT_W-1:0] amount;
  } palette_op_t;

  typedef struct {
    logic [ptcc_pkg::BYTE_W-1:0] red;
    logic [ptcc_pkg::BYTE_W-1:0] green;
    logic [ptcc_pkg::BYTE_W-1:0] blue;
    ptcc_pkg::status_t           stat;
  } palette_result_t;

  logic                            clk;
  logic                            rst           = 1'b1;
  logic                            psel          = 1'b0;
  logic                            penable       = 1'b0;
  logic                            pwrite        = 1'b0;
  logic [ptcc_pkg::APB_ADDR_W-1:0] paddr         = '0;
  logic [ptcc_pkg::APB_DATA_W-1:0] pwdata        = '0;
  logic [ptcc_pkg::APB_DATA_W-1:0] prdata;
  logic                            pready;
  logic                            start         = 1'b0;
  logic                            busy;
  logic [1:0]                      opcode        = ptcc_pkg::OP_NOP;
  logic [ptcc_pkg::BYTE_W-1:0]     load_byte     = '0;
  logic                            load_last     = 1'b0;
  logic [ptcc_pkg::INDEX_W-1:0]    read_index    = '0;
  logic [ptcc_pkg::INDEX_W-1:0]    range_first   = '0;
  logic [ptcc_pkg::INDEX_W-1:0]    range_final   = '0;
  logic [ptcc_pkg::AMOUNT_W-1:0]   rotate_amount = '0;
  logic                            done;
  logic [ptcc_pkg::BYTE_W-1:0]     red;
  logic [ptcc_pkg::BYTE_W-1:0]     green;
  logic [ptcc_pkg::BYTE_W-1:0]     blue;
  logic [1:0]                      status;

  palette_op_t     op_queue[$];
  palette_result_t color_expect[$];
  palette_op_t     cur;
  logic            taken   = 1'b0;
  logic            gaps_on = 1'b1;
  int              mismatches = 0;

  // palette model
  logic [ptcc_pkg::COLOR_W-1:0]   palette_model [ENTRIES];
  int unsigned                    load_count = 0;
  logic [ptcc_pkg::PARTIAL_W-1:0] partial    = '0;
  logic [ptcc_pkg::CFG_W-1:0]     fmt_reg    = ptcc_pkg::BPE_RESET;

  palette_table_with_color_cycling DUT (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .start(start), .busy(busy), .opcode(opcode), .load_byte(load_byte),
    .load_last(load_last), .read_index(read_index), .range_first(range_first),
    .range_final(range_final), .rotate_amount(rotate_amount),
    .done(done), .red(red), .green(green), .blue(blue), .status(status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: %s got %0h expected %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic palette_result_t apply_op(input palette_op_t it);
    palette_result_t              res;
    int unsigned                  per_entry, pos, slot, span, shift;
    logic [ptcc_pkg::COLOR_W-1:0] staged [ENTRIES];
    res.red   = '0;
    res.green = '0;
    res.blue  = '0;
    res.stat  = ptcc_pkg::STAT_OK;
    case (it.op)
      ptcc_pkg::OP_LOAD: begin
        per_entry = (fmt_reg == ptcc_pkg::BPE_FOUR) ? 4 : 3;
        pos  = load_count % per_entry;
        slot = load_count / per_entry;
        if (pos == 0) begin
          partial = {it.byte_val, 8'h00};
        end else if (pos == 1) begin
          partial[7:0] = it.byte_val;
        end else if (pos == 2 && slot < ENTRIES) begin
          palette_model[slot] = {partial, it.byte_val};
        end
        if (load_count < COUNT_LIMIT) load_count++;
        if (it.is_last) begin
          if (load_count != ENTRIES * per_entry) res.stat = ptcc_pkg::STAT_LOAD_LEN;
          load_count = 0;
          partial = '0;
        end
      end
      ptcc_pkg::OP_READ: begin
        if (it.rd_index < ENTRIES) {res.red, res.green, res.blue} = palette_model[it.rd_index];
      end
      ptcc_pkg::OP_ROTATE: begin
        if (it.top_idx < it.first || it.top_idx >= ENTRIES) begin
          res.stat = ptcc_pkg::STAT_RANGE;
        end else begin
          span  = it.top_idx - it.first + 1;
          shift = it.amount % span;
          for (int i = 0; i < span; i++) staged[(i + shift) % span] = palette_model[it.first + i];
          for (int i = 0; i < span; i++) palette_model[it.first + i] = staged[i];
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // driver
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || taken) begin
      if (op_queue.size() != 0 && !(gaps_on && $urandom_range(99) < IDLE_PCT)) begin
        cur = op_queue.pop_front();
        start         <= 1'b1;
        opcode        <= cur.op;
        load_byte     <= cur.byte_val;
        load_last     <= cur.is_last;
        read_index    <= cur.rd_index;
        range_first   <= cur.first;
        range_final   <= cur.top_idx;
        rotate_amount <= cur.amount;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin : monitor
    palette_result_t want;
    taken = 1'b0;
    if (!rst) begin
      if (done) begin
        if (color_expect.size() == 0) begin
          report_mismatch("result with no transaction outstanding, status", 32'(status), 0);
        end else begin
          want = color_expect.pop_front();
          if (red !== want.red) report_mismatch("red", 32'(red), 32'(want.red));
          if (green !== want.green) report_mismatch("green", 32'(green), 32'(want.green));
          if (blue !== want.blue) report_mismatch("blue", 32'(blue), 32'(want.blue));
          if (status !== want.stat) report_mismatch("status", 32'(status), 32'(want.stat));
        end
      end
      if (start && !busy) begin
        color_expect.push_back(apply_op(cur));
        taken = 1'b1;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || done) quiet = 0;
      else quiet++;
    end
    $display("palette_table_with_color_cycling: mismatch");
    $finish;
  end

  function automatic palette_op_t random_op(input ptcc_pkg::opcode_t op);
    palette_op_t it;
    it.op       = op;
    it.byte_val = ptcc_pkg::BYTE_W'($urandom);
    it.is_last  = 1'($urandom_range(1));
    it.rd_index = ptcc_pkg::INDEX_W'($urandom);
    it.first    = ptcc_pkg::INDEX_W'($urandom);
    it.top_idx  = ptcc_pkg::INDEX_W'($urandom);
    it.amount   = ptcc_pkg::AMOUNT_W'($urandom);
    return it;
  endfunction

  function automatic palette_op_t load_op(input logic [ptcc_pkg::BYTE_W-1:0] b,
                                          input logic is_last);
    palette_op_t it;
    it = random_op(ptcc_pkg::OP_LOAD);
    it.byte_val = b;
    it.is_last  = is_last;
    return it;
  endfunction

  function automatic palette_op_t read_op(input logic [ptcc_pkg::INDEX_W-1:0] idx);
    palette_op_t it;
    it = random_op(ptcc_pkg::OP_READ);
    it.rd_index = idx;
    return it;
  endfunction

  function automatic palette_op_t rotate_op(input logic [ptcc_pkg::INDEX_W-1:0] f,
                                            input logic [ptcc_pkg::INDEX_W-1:0] t,
                                            input logic [ptcc_pkg::AMOUNT_W-1:0] amt);
    palette_op_t it;
    it = random_op(ptcc_pkg::OP_ROTATE);
    it.first   = f;
    it.top_idx = t;
    it.amount  = amt;
    return it;
  endfunction

  // mostly short ranges, a few full-palette and inverted ones
  function automatic palette_op_t random_rotate();
    int f, t, pick;
    logic [ptcc_pkg::AMOUNT_W-1:0] amt;
    pick = $urandom_range(99);
    f = $urandom_range(ENTRIES - 1);
    amt = $urandom_range(1) ? ptcc_pkg::AMOUNT_W'($urandom)
                            : ptcc_pkg::AMOUNT_W'($urandom_range(20));
    if (pick < 10) begin
      if (f == 0) f = $urandom_range(ENTRIES - 1, 1);
      t = $urandom_range(f - 1);
    end else if (pick < 15) begin
      f = 0;
      t = ENTRIES - 1;
    end else begin
      t = f + $urandom_range(15);
      if (t > ENTRIES - 1) t = ENTRIES - 1;
    end
    return rotate_op(ptcc_pkg::INDEX_W'(f), ptcc_pkg::INDEX_W'(t), amt);
  endfunction

  task automatic queue_mix(input int count);
    int pick;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        op_queue.push_back(load_op(ptcc_pkg::BYTE_W'($urandom), $urandom_range(11) == 0));
      end else if (pick < 75) begin
        op_queue.push_back(read_op(ptcc_pkg::INDEX_W'($urandom)));
      end else if (pick < 96) begin
        op_queue.push_back(random_rotate());
      end else begin
        op_queue.push_back(random_op(ptcc_pkg::OP_NOP));
      end
    end
  endtask

  // a run of load bytes with reads and rotates slipped in between
  task automatic queue_load(input int nbytes, input bit close, input int mix_pct);
    for (int i = 0; i < nbytes; i++) begin
      if ($urandom_range(99) < mix_pct) begin
        if ($urandom_range(1)) op_queue.push_back(read_op(ptcc_pkg::INDEX_W'($urandom)));
        else op_queue.push_back(random_rotate());
      end
      op_queue.push_back(load_op(ptcc_pkg::BYTE_W'($urandom), close && i == nbytes - 1));
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (op_queue.size() != 0 || start || color_expect.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_format(input logic [ptcc_pkg::CFG_W-1:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ptcc_pkg::REG_BYTES_PER_ENTRY;
    pwdata  <= ptcc_pkg::APB_DATA_W'(val);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    fmt_reg = val;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== ptcc_pkg::APB_DATA_W'(val)) begin
      report_mismatch("format readback", prdata, 32'(val));
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    for (int i = 0; i < ENTRIES; i++) palette_model[i] = '0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // 3-byte format out of reset
    op_queue.push_back(read_op(8'h00));
    op_queue.push_back(read_op(8'hFF));
    op_queue.push_back(load_op(8'hFF, 1'b0));
    op_queue.push_back(load_op(8'h00, 1'b0));
    op_queue.push_back(load_op(8'hFF, 1'b0));
    op_queue.push_back(load_op(8'h00, 1'b0));
    op_queue.push_back(load_op(8'hFF, 1'b0));
    op_queue.push_back(load_op(8'h00, 1'b1));
    op_queue.push_back(read_op(8'h00));
    op_queue.push_back(read_op(8'h01));
    op_queue.push_back(load_op(8'h5A, 1'b1));
    op_queue.push_back(rotate_op(8'd0, 8'd1, 16'd1));
    op_queue.push_back(read_op(8'h00));
    op_queue.push_back(read_op(8'h01));
    op_queue.push_back(rotate_op(8'd0, 8'd255, 16'hFFFF));
    op_queue.push_back(read_op(8'hFF));
    op_queue.push_back(read_op(8'h00));
    op_queue.push_back(rotate_op(8'd5, 8'd4, 16'd3));
    op_queue.push_back(rotate_op(8'd255, 8'd0, 16'd0));
    op_queue.push_back(rotate_op(8'd200, 8'd200, 16'hFFFF));
    op_queue.push_back(read_op(8'd200));
    op_queue.push_back(random_op(ptcc_pkg::OP_NOP));
    wait_drained();

    // 4-byte format, fourth byte dropped
    set_format(ptcc_pkg::BPE_FOUR);
    op_queue.push_back(load_op(8'h12, 1'b0));
    op_queue.push_back(load_op(8'h34, 1'b0));
    op_queue.push_back(load_op(8'h56, 1'b0));
    op_queue.push_back(load_op(8'hAA, 1'b0));
    op_queue.push_back(load_op(8'h00, 1'b0));
    op_queue.push_back(load_op(8'hFF, 1'b0));
    op_queue.push_back(load_op(8'h80, 1'b0));
    op_queue.push_back(load_op(8'hFF, 1'b1));
    op_queue.push_back(read_op(8'h00));
    op_queue.push_back(read_op(8'h01));
    queue_mix(30);
    wait_drained();

    // full-length load begun in the 4-byte format and finished in the 3-byte format
    // (format value 0), without idle gaps
    gaps_on = 1'b0;
    op_queue.push_back(load_op(ptcc_pkg::BYTE_W'($urandom), 1'b1));
    queue_load(FIRST_PART, 1'b0, 8);
    wait_drained();
    set_format(ptcc_pkg::CFG_W'(0));
    queue_load(ENTRIES * 3 - FIRST_PART, 1'b1, 2);
    for (int i = 0; i < 4; i++) op_queue.push_back(read_op(ptcc_pkg::INDEX_W'(i)));
    wait_drained();
    gaps_on = 1'b1;

    set_format(ptcc_pkg::CFG_W'(5));
    queue_mix(12);
    wait_drained();

    if (mismatches == 0) begin
      $display("palette_table_with_color_cycling: match");
    end else begin
      $display("palette_table_with_color_cycling: mismatch");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/ptcc_pkg.sv
sv/palette_table_with_color_cycling.sv
sv/ptcc_checker.sv
bench/tb.sv
